/* rtl/core/isws_pkg.sv */
`timescale 1ns / 1ps

package isws_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int WORD_W        = 32;
   localparam int ACTION_W      = 3;
   localparam int STATUS_W      = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH  = 3'd0,
      ACT_POP   = 3'd1,
      ACT_PEEK  = 3'd2,
      ACT_READ  = 3'd3,
      ACT_WRITE = 3'd4,
      ACT_SORT  = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_UNDER = 2'd1,
      STAT_OVER  = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SORT
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_SORT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        phase;
   } cell_cmd_type;

endpackage

/* rtl/core/isws_cell.sv */
`timescale 1ns / 1ps

module isws_cell #(
   parameter int POS   = 0,
   parameter int IDX_W = 6,
   parameter int CNT_W = 7
) (
   input  logic                                clock,
   input  isws_pkg::cell_cmd_type              cmd,
   input  logic [IDX_W-1:0]                    ld_index,
   input  logic signed [isws_pkg::WORD_W-1:0]  ld_value,
   input  logic [IDX_W-1:0]                    rd_index,
   input  logic [CNT_W-1:0]                    count,
   input  logic signed [isws_pkg::WORD_W-1:0]  below,
   input  logic signed [isws_pkg::WORD_W-1:0]  above,
   input  logic signed [isws_pkg::WORD_W-1:0]  rd_prev,
   output logic signed [isws_pkg::WORD_W-1:0]  word,
   output logic signed [isws_pkg::WORD_W-1:0]  rd_out
);
   import isws_pkg::*;

   localparam logic [IDX_W-1:0] ME        = IDX_W'(POS);
   localparam logic [CNT_W-1:0] ME_C      = CNT_W'(POS);
   localparam logic [CNT_W-1:0] NEXT_C    = CNT_W'(POS + 1);
   localparam bit               HAS_BELOW = (POS > 0);

   logic signed [WORD_W-1:0] word_ff, word_in;
   logic signed [WORD_W-1:0] rd_ff, rd_in;
   logic                     lower, upper;

   // pair membership for this round of the odd-even exchange
   assign lower = (ME[0] == cmd.phase) && (NEXT_C < count);
   assign upper = HAS_BELOW && (ME[0] != cmd.phase) && (ME_C < count);

   always_comb begin
      word_in = word_ff;
      case (cmd.op)
         CELL_LOAD: begin
            if (ld_index == ME) begin
               word_in = ld_value;
            end
         end
         CELL_SORT: begin
            if (lower && (above < word_ff)) begin
               word_in = above;
            end else if (upper && (word_ff < below)) begin
               word_in = below;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   // read bus passes one cell per cycle, the selected cell ors its word in
   assign rd_in = rd_prev | ((rd_index == ME) ? word_ff : '0);

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      rd_ff   <= rd_in;
   end

   assign word   = word_ff;
   assign rd_out = rd_ff;

endmodule

/* rtl/core/indexed_stack_with_insertion_sort.sv */
`timescale 1ns / 1ps
// channel  direction  handshake           payload
// req      in         req_valid/req_stall action, value, index
// rsp      out        rsp_valid/rsp_stall data, count, is_empty, status
//
// push, pop, write, rejected requests and sort of under two entries: result registered
// peek and read: result taken from the read bus that walks the cell row
// sort: one odd-even exchange round across the row per cycle
// reset clears the fill count and control only; entries are undefined until written
// a new word is taken only in idle with the result register free or draining

module indexed_stack_with_insertion_sort #(
   parameter  int DEPTH = isws_pkg::DEPTH_DEFAULT,
   localparam int IDX_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [isws_pkg::ACTION_W-1:0]       req_action,
   input  logic signed [isws_pkg::WORD_W-1:0]  req_value,
   input  logic [IDX_W-1:0]                    req_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [isws_pkg::WORD_W-1:0]  rsp_data,
   output logic [CNT_W-1:0]                    rsp_count,
   output logic                                rsp_is_empty,
   output logic [isws_pkg::STATUS_W-1:0]       rsp_status
);
   import isws_pkg::*;

   localparam logic [CNT_W-1:0] FULL_C = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE_C  = CNT_W'(1);

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic [IDX_W-1:0]         target_ff, target_in;
   logic [CNT_W-1:0]         step_ff, step_in;
   logic [CNT_W-1:0]         round_ff, round_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_W-1:0] rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0]         rsp_count_ff, rsp_count_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;

   logic         accept, is_full, is_empty_now, idx_ok;
   logic         start_read, start_sort, read_done, sort_done, respond;
   action_type   act;
   cell_cmd_type cmd;
   logic [IDX_W-1:0] ld_index;

   logic signed [WORD_W-1:0] words [DEPTH];
   logic signed [WORD_W-1:0] rd_bus [DEPTH];

   assign req_stall    = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept       = req_valid && !req_stall;
   assign act          = action_type'(req_action);
   assign is_full      = (fill_ff == FULL_C);
   assign is_empty_now = (fill_ff == '0);
   assign idx_ok       = (CNT_W'(req_index) < fill_ff);

   assign start_read = accept && (((act == ACT_PEEK) && !is_empty_now)
                                  || ((act == ACT_READ) && idx_ok));
   assign start_sort = accept && (act == ACT_SORT) && (fill_ff > ONE_C);
   assign read_done  = (state_ff == ST_READ) && (step_ff == FULL_C);
   assign sort_done  = (state_ff == ST_SORT) && (round_ff == (fill_ff - ONE_C));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_read) begin
               state_in = ST_READ;
            end else if (start_sort) begin
               state_in = ST_SORT;
            end
         end
         ST_READ: begin
            if (read_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_SORT: begin
            if (sort_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and result
   always_comb begin
      fill_in       = fill_ff;
      target_in     = target_ff;
      step_in       = step_ff;
      round_in      = round_ff;
      cmd.op        = CELL_HOLD;
      cmd.phase     = round_ff[0];
      ld_index      = req_index;
      respond       = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in  = '0;
            round_in = '0;
            if (accept) begin
               rsp_data_in   = '0;
               rsp_status_in = STAT_OK;
               respond       = !(start_read || start_sort);
               case (act)
                  ACT_PUSH: begin
                     if (is_full) begin
                        rsp_status_in = STAT_OVER;
                     end else begin
                        cmd.op   = CELL_LOAD;
                        ld_index = IDX_W'(fill_ff);
                        fill_in  = fill_ff + ONE_C;
                     end
                  end
                  ACT_POP: begin
                     if (is_empty_now) begin
                        rsp_status_in = STAT_UNDER;
                     end else begin
                        fill_in = fill_ff - ONE_C;
                     end
                  end
                  ACT_PEEK: begin
                     if (is_empty_now) begin
                        rsp_status_in = STAT_UNDER;
                     end else begin
                        target_in = IDX_W'(fill_ff - ONE_C);
                     end
                  end
                  ACT_READ: begin
                     if (!idx_ok) begin
                        rsp_status_in = STAT_RANGE;
                     end else begin
                        target_in = req_index;
                     end
                  end
                  ACT_WRITE: begin
                     if (!idx_ok) begin
                        rsp_status_in = STAT_RANGE;
                     end else begin
                        cmd.op = CELL_LOAD;
                     end
                  end
                  default: begin
                     rsp_status_in = STAT_OK;
                  end
               endcase
               rsp_count_in = fill_in;
            end
         end
         ST_READ: begin
            step_in = step_ff + ONE_C;
            if (read_done) begin
               respond       = 1'b1;
               rsp_data_in   = rd_bus[DEPTH-1];
               rsp_count_in  = fill_ff;
               rsp_status_in = STAT_OK;
            end
         end
         ST_SORT: begin
            cmd.op   = CELL_SORT;
            round_in = round_ff + ONE_C;
            if (sort_done) begin
               respond       = 1'b1;
               rsp_data_in   = '0;
               rsp_count_in  = fill_ff;
               rsp_status_in = STAT_OK;
            end
         end
         default: begin
            cmd.op = CELL_HOLD;
         end
      endcase
      if (respond) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      target_ff     <= target_in;
      step_ff       <= step_in;
      round_ff      <= round_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   // row of cells, one entry each
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic signed [WORD_W-1:0] below_w, above_w, rd_prev_w;
      if (k == 0) begin : g_first
         assign below_w   = '0;
         assign rd_prev_w = '0;
      end else begin : g_inner_lo
         assign below_w   = words[k-1];
         assign rd_prev_w = rd_bus[k-1];
      end
      if (k == DEPTH - 1) begin : g_last
         assign above_w = '0;
      end else begin : g_inner_hi
         assign above_w = words[k+1];
      end
      isws_cell #(
         .POS   (k),
         .IDX_W (IDX_W),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .ld_index (ld_index),
         .ld_value (req_value),
         .rd_index (target_ff),
         .count    (fill_ff),
         .below    (below_w),
         .above    (above_w),
         .rd_prev  (rd_prev_w),
         .word     (words[k]),
         .rd_out   (rd_bus[k])
      );
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_is_empty = (rsp_count_ff == '0);
   assign rsp_status   = rsp_status_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_C)
      else $error("fill count beyond depth");

   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid_ff || (state_ff != ST_IDLE)))
      else $error("accepted word left no result and no work");

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("request taken while busy");

   a_fill_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(fill_ff))
      else $error("fill count moved without a request");

   a_busy_slot: assert property (@(posedge clock) disable iff (reset)
      ((state_ff != ST_IDLE) && !read_done && !sort_done) |=> !respond || !rsp_valid_ff
         || !rsp_stall)
      else $error("result slot overrun");

endmodule
